@@ src/fns_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fns_pkg: shared types and constants for the short name formatter
// Holds the queue entry layout, character codes and the case helper.
// ----------------------------------------------------------------------------
package fns_pkg;

	// layout of the padded short name
	localparam int BASE_LEN = 8;
	localparam int EXT_LEN  = 3;

	// case flag bit positions
	localparam int FLAG_BASE_LOWER_BIT = 3;
	localparam int FLAG_EXT_LOWER_BIT  = 4;

	// character codes
	localparam logic [7:0] CHAR_NUL    = 8'h00;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_PERIOD = 8'h2E;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	// queue between classifier and sequencer
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// width of a name position (up to twelve characters)
	localparam int POS_W = 4;

	typedef struct packed {
		logic [BASE_LEN-1:0][7:0] base_chars;
		logic [EXT_LEN-1:0][7:0]  ext_chars;
		logic [POS_W-1:0]         base_len;
		logic [POS_W-1:0]         name_len;
	} entry_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c == CHAR_NUL);
	endfunction

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

endpackage

@@ src/fns_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fns_front: entry classifier
// Finds base and extension lengths, applies lower case and clips the
// name length to the room, producing one queue entry per accepted beat.
// ----------------------------------------------------------------------------
module fns_front (
	input  logic [63:0]          base_bytes,
	input  logic [23:0]          ext_bytes,
	input  logic [7:0]           case_flags,
	input  logic [4:0]           buffer_room,
	output logic                 has_room,
	output fns_pkg::entry_t      entry
);

	logic                           base_low;
	logic                           ext_low;
	logic [fns_pkg::POS_W-1:0]      base_len;
	logic [1:0]                     ext_len;
	logic [fns_pkg::POS_W-1:0]      total_len;
	logic [4:0]                     room_m1;

	assign base_low = case_flags[fns_pkg::FLAG_BASE_LOWER_BIT];
	assign ext_low  = case_flags[fns_pkg::FLAG_EXT_LOWER_BIT];
	assign has_room = (buffer_room != 5'd0);
	assign room_m1  = buffer_room - 5'd1;

	// base ends at first blank byte
	always_comb begin
		base_len = fns_pkg::POS_W'(fns_pkg::BASE_LEN);
		for (int i = fns_pkg::BASE_LEN - 1; i >= 0; i--) begin
			if (fns_pkg::is_blank(base_bytes[8*i +: 8])) begin
				base_len = fns_pkg::POS_W'(i);
			end
		end
	end

	// extension ends at first blank byte; zero length means no period
	always_comb begin
		ext_len = 2'd3;
		for (int i = fns_pkg::EXT_LEN - 1; i >= 0; i--) begin
			if (fns_pkg::is_blank(ext_bytes[8*i +: 8])) begin
				ext_len = 2'(i);
			end
		end
	end

	// total length, with the period when there is an extension; clipped to room minus one at assembly
	always_comb begin
		total_len = base_len;
		if (ext_len != 2'd0) begin
			total_len = base_len + fns_pkg::POS_W'(ext_len) + fns_pkg::POS_W'(1);
		end
	end

	// case conversion and entry assembly
	always_comb begin
		for (int i = 0; i < fns_pkg::BASE_LEN; i++) begin
			entry.base_chars[i] = base_low ? fns_pkg::lower_ascii(base_bytes[8*i +: 8])
			                               : base_bytes[8*i +: 8];
		end
		for (int i = 0; i < fns_pkg::EXT_LEN; i++) begin
			entry.ext_chars[i] = ext_low ? fns_pkg::lower_ascii(ext_bytes[8*i +: 8])
			                             : ext_bytes[8*i +: 8];
		end
		entry.base_len = base_len;
		if ({1'b0, total_len} > room_m1) begin
			entry.name_len = room_m1[fns_pkg::POS_W-1:0];
		end else begin
			entry.name_len = total_len;
		end
	end

endmodule

@@ src/fns_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fns_queue: short entry queue
// Small register queue that decouples the classifier from the sequencer.
// ----------------------------------------------------------------------------
module fns_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fns_pkg::entry_t     push_entry,
	input  logic                pop,
	output logic                full,
	output logic                empty,
	output fns_pkg::entry_t     head
);

	fns_pkg::entry_t                   slots_q [fns_pkg::QUEUE_DEPTH];
	logic [fns_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [fns_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [fns_pkg::QCNT_W-1:0]        count_q;

	assign full  = (count_q == fns_pkg::QCNT_W'(fns_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == fns_pkg::QPTR_W'(fns_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + fns_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == fns_pkg::QPTR_W'(fns_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + fns_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + fns_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - fns_pkg::QCNT_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	// no write into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("fns_queue: push while full");
	// no read from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("fns_queue: pop while empty");
	// fill count follows a push without a pop
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + fns_pkg::QCNT_W'(1)))
		else $error("fns_queue: count did not follow push");
`endif

endmodule

@@ src/fns_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fns_back: character sequencer
// Walks the head entry one character per cycle while not empty: base, period,
// extension up to the name length, then the zero terminator, popping with it.
// ----------------------------------------------------------------------------
module fns_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  fns_pkg::entry_t     head,
	output logic                pop,
	output logic                valid,
	output logic [7:0]          out_char,
	output logic                is_last
);

	logic [fns_pkg::POS_W-1:0]  pos_q;
	logic [1:0]                 ext_off;
	logic                       at_end;
	logic [7:0]                 cur_char;
	logic                       valid_q;
	logic                       is_last_q;
	logic [7:0]                 char_q;

	assign at_end  = (pos_q == head.name_len);
	assign pop     = !empty && at_end;
	assign ext_off = 2'(pos_q - head.base_len - fns_pkg::POS_W'(1));

	// character select for the current position
	always_comb begin
		priority if (at_end) begin
			cur_char = fns_pkg::CHAR_NUL;
		end else if (pos_q < head.base_len) begin
			cur_char = head.base_chars[pos_q[2:0]];
		end else if (pos_q == head.base_len) begin
			cur_char = fns_pkg::CHAR_PERIOD;
		end else begin
			cur_char = head.ext_chars[ext_off];
		end
	end

	// position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (!empty) begin
			pos_q <= at_end ? '0 : pos_q + fns_pkg::POS_W'(1);
		end
	end

	// output register, one beat per cycle while the queue is not empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			is_last_q <= 1'b0;
		end else begin
			valid_q   <= !empty;
			is_last_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		char_q <= cur_char;
	end

	assign valid    = valid_q;
	assign out_char = char_q;
	assign is_last  = is_last_q;

`ifndef NO_ASSERTIONS
	// terminator only marks a real beat
	assert property (@(posedge clk) disable iff (!arst_n) is_last |-> valid)
		else $error("fns_back: last mark without beat");
	// terminator carries zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid && is_last) |-> (out_char == fns_pkg::CHAR_NUL))
		else $error("fns_back: terminator not zero");
	// position never runs past the name
	assert property (@(posedge clk) disable iff (!arst_n) !empty |-> (pos_q <= head.name_len))
		else $error("fns_back: position past name length");
`endif

endmodule

@@ src/fat_short_name_formatter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_short_name_formatter_core: FAT 8.3 short name to string
// Turns a padded directory entry name into its printable characters.
// ----------------------------------------------------------------------------
// An entry is taken when start is high and busy is low; the classifier
// works it out in that cycle and places it in a two-entry queue, and busy
// is high only while that queue is full. The output sequencer sends one
// character per cycle, so an entry gives its clipped name length plus one
// beats at the output (1 to 13), the last beat being a zero with is_last
// set; a buffer_room of zero is accepted and produces no beats. Beats are
// marked by valid for one cycle each and must be taken as they come, and
// the first beat of an entry passes from the queue through the sequencer's
// output register to the outputs when the sequencer is free.
module fat_short_name_formatter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] base_bytes,
	input  logic [23:0] ext_bytes,
	input  logic [7:0]  case_flags,
	input  logic [4:0]  buffer_room,
	output logic        valid,
	output logic [7:0]  out_char,
	output logic        is_last
);

	fns_pkg::entry_t    new_entry;
	fns_pkg::entry_t    head;
	logic               has_room;
	logic               push;
	logic               pop;
	logic               full;
	logic               empty;

	// classify the incoming beat
	fns_front u_front (
		.base_bytes  (base_bytes),
		.ext_bytes   (ext_bytes),
		.case_flags  (case_flags),
		.buffer_room (buffer_room),
		.has_room    (has_room),
		.entry       (new_entry)
	);

	assign busy = full;
	assign push = start && !full && has_room;

	// decoupling queue
	fns_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (new_entry),
		.pop        (pop),
		.full       (full),
		.empty      (empty),
		.head       (head)
	);

	// character sequencer
	fns_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.valid    (valid),
		.out_char (out_char),
		.is_last  (is_last)
	);

endmodule
